/* src/vnt_pkg.sv */
`timescale 1ns / 1ps
package vnt_pkg;

  // Table geometry and blend precision
  localparam int TABLE_WIDTH  = 64;
  localparam int TABLE_HEIGHT = 64;
  localparam int TABLE_DEPTH  = 16;
  localparam int SAMPLE_BITS  = 16;

  // Fixed field widths
  localparam int COORD_W   = 24;
  localparam int FRAC_W    = 8;
  localparam int VAL_W     = 16;
  localparam int ADDR_W    = 16;
  localparam int CFG_W     = 4;
  localparam int MAX_START = 8;
  localparam int SUM_W     = VAL_W + MAX_START + 1;
  localparam int SHIFT_W   = 5;

  localparam int XW = $clog2(TABLE_WIDTH);
  localparam int YW = $clog2(TABLE_HEIGHT);
  localparam int ZW = $clog2(TABLE_DEPTH);

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_LOAD   = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                command;
    logic [COORD_W-1:0]  x_coord;
    logic [COORD_W-1:0]  y_coord;
    logic [COORD_W-1:0]  z_coord;
    logic [ADDR_W-1:0]   entry_address;
    logic [VAL_W-1:0]    entry_value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

/* src/value_noise_turbulence_3d_core.sv */
`timescale 1ns / 1ps
// Turbulence over a stored 3D value-noise table.
// Input channel (in_valid / in_stall): each request is either a table load
// (in_command = 1, in_entry_address, in_entry_value) or a sample
// (in_command = 0, Q16.8 point in_x_coord, in_y_coord, in_z_coord).
// Loads produce no result; each sample produces one Q8.8 result on the
// output channel (out_valid / out_stall, out_turbulence_value).
// cfg_we / cfg_wdata set start_size_log2 (reset 5, values above 8 act as 8);
// write it only while the block is idle.
// Requests enter a two-entry queue; the sequencer behind it handles one
// request at a time. A load is written to the table as it is popped. A
// sample is popped, then per octave the sequencer runs a setup step, reads
// the eight corners through the single table read port, waits on the
// registered read data and blends on the shared blend multiplier pair;
// last it posts the result.
// After reset the queue is empty, no result is pending and table contents
// are undefined until loaded. When out_stall is high the result holds in the
// output register; the queue keeps taking requests until full, then
// in_stall rises.
module value_noise_turbulence_3d_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic [vnt_pkg::COORD_W-1:0]  in_x_coord,
  input  logic [vnt_pkg::COORD_W-1:0]  in_y_coord,
  input  logic [vnt_pkg::COORD_W-1:0]  in_z_coord,
  input  logic [vnt_pkg::ADDR_W-1:0]   in_entry_address,
  input  logic [vnt_pkg::VAL_W-1:0]    in_entry_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [vnt_pkg::VAL_W-1:0]    out_turbulence_value,
  input  logic                         cfg_we,
  input  logic [vnt_pkg::CFG_W-1:0]    cfg_wdata
);
  import vnt_pkg::*;

  logic [CFG_W-1:0] start_r;
  item_t            in_item;
  q_head_t          head;
  logic             pop;

  // Hold the start size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= CFG_W'(5);
    end else if (cfg_we) begin
      start_r <= cfg_wdata;
    end
  end

  assign in_item.command       = cmd_t'(in_command);
  assign in_item.x_coord       = in_x_coord;
  assign in_item.y_coord       = in_y_coord;
  assign in_item.z_coord       = in_z_coord;
  assign in_item.entry_address = in_entry_address;
  assign in_item.entry_value   = in_entry_value;

  vnt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .head     (head),
    .pop      (pop)
  );

  vnt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_start (start_r),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_turbulence_value)
  );

endmodule

/* src/vnt_front.sv */
`timescale 1ns / 1ps
module vnt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vnt_pkg::item_t    in_item,
  output vnt_pkg::q_head_t  head,
  input  logic              pop
);
  import vnt_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t           q_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            push;
  logic            do_pop;

  // Stall while the queue is full
  assign in_stall = (cnt_r == CW'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (cnt_r != '0);

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rd_ptr_r];

  // Store accepted requests
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(do_pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CW'(QUEUE_DEPTH)) && !pop |=> in_stall) else $error("full queue not stalled");

endmodule

/* src/vnt_back.sv */
`timescale 1ns / 1ps
module vnt_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [vnt_pkg::CFG_W-1:0] cfg_start,
  input  vnt_pkg::q_head_t         head,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [vnt_pkg::VAL_W-1:0] out_value
);
  import vnt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DONE
  } state_t;

  localparam logic [31:0] PLANE = 32'(TABLE_HEIGHT * TABLE_WIDTH);
  localparam logic [31:0] ROW   = 32'(TABLE_WIDTH);
  localparam logic [3:0]  LAST_STEP = 4'd15;

  state_t              state_r;
  logic [CFG_W-1:0]    oct_r;
  logic [3:0]          step_r;
  logic [SUM_W-1:0]    sum_r;
  logic                out_valid_r;
  logic [VAL_W-1:0]    out_value_r;

  logic [COORD_W-1:0]  x_r, y_r, z_r;
  logic [XW-1:0]       cx_r, cmx_r;
  logic [YW-1:0]       cy_r, cmy_r;
  logic [ZW-1:0]       cz_r, cmz_r;
  logic [SAMPLE_BITS-1:0] fx_r, fy_r, fz_r;
  logic [VAL_W-1:0]    v_r [8];

  logic [VAL_W-1:0]    mem [2**ADDR_W];
  logic [VAL_W-1:0]    rd_data_r;
  logic [ADDR_W-1:0]   rd_addr;
  logic                mem_we;

  logic [CFG_W-1:0]    start_sat;
  logic [SHIFT_W-1:0]  sh;
  logic [COORD_W-1:0]  ipx, ipy, ipz;
  logic [COORD_W+SAMPLE_BITS-1:0] frx, fry, frz;
  logic [XW-1:0]       cx_n;
  logic [YW-1:0]       cy_n;
  logic [ZW-1:0]       cz_n;

  logic [XW-1:0]       xsel;
  logic [YW-1:0]       ysel;
  logic [ZW-1:0]       zsel;
  logic [31:0]         idx_full;

  logic [VAL_W-1:0]    bl_a, bl_b;
  logic [SAMPLE_BITS-1:0] bl_f;
  logic [SAMPLE_BITS:0]   bl_fc;
  logic [VAL_W+SAMPLE_BITS+1:0] bl_p;
  logic [VAL_W-1:0]    bl_res;

  assign start_sat = (cfg_start > CFG_W'(MAX_START)) ? CFG_W'(MAX_START) : cfg_start;
  assign pop       = (state_r == ST_IDLE) && head.valid;
  assign mem_we    = pop && (head.item.command == CMD_LOAD);
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  // Split each axis into cell and fraction for the current octave
  assign sh   = SHIFT_W'(FRAC_W) + SHIFT_W'(oct_r);
  assign ipx  = x_r >> sh;
  assign ipy  = y_r >> sh;
  assign ipz  = z_r >> sh;
  assign frx  = {x_r, {SAMPLE_BITS{1'b0}}} >> sh;
  assign fry  = {y_r, {SAMPLE_BITS{1'b0}}} >> sh;
  assign frz  = {z_r, {SAMPLE_BITS{1'b0}}} >> sh;
  assign cx_n = XW'(ipx % TABLE_WIDTH);
  assign cy_n = YW'(ipy % TABLE_HEIGHT);
  assign cz_n = ZW'(ipz % TABLE_DEPTH);

  // Corner address: bit 0 picks x neighbor, bit 1 y, bit 2 z
  assign xsel     = step_r[0] ? cmx_r : cx_r;
  assign ysel     = step_r[1] ? cmy_r : cy_r;
  assign zsel     = step_r[2] ? cmz_r : cz_r;
  assign idx_full = 32'(zsel) * PLANE + 32'(ysel) * ROW + 32'(xsel);
  assign rd_addr  = idx_full[ADDR_W-1:0];

  // Select blend operands by step
  always_comb begin
    bl_a = v_r[0];
    bl_b = v_r[1];
    bl_f = fx_r;
    case (step_r)
      4'd9:  begin bl_a = v_r[0]; bl_b = v_r[1]; bl_f = fx_r; end
      4'd10: begin bl_a = v_r[2]; bl_b = v_r[3]; bl_f = fx_r; end
      4'd11: begin bl_a = v_r[4]; bl_b = v_r[5]; bl_f = fx_r; end
      4'd12: begin bl_a = v_r[6]; bl_b = v_r[7]; bl_f = fx_r; end
      4'd13: begin bl_a = v_r[0]; bl_b = v_r[2]; bl_f = fy_r; end
      4'd14: begin bl_a = v_r[4]; bl_b = v_r[6]; bl_f = fy_r; end
      4'd15: begin bl_a = v_r[0]; bl_b = v_r[4]; bl_f = fz_r; end
      default: begin bl_a = v_r[0]; bl_b = v_r[1]; bl_f = fx_r; end
    endcase
  end

  // Weighted blend of corner c and neighbor c-1
  assign bl_fc  = (SAMPLE_BITS+1)'(2**SAMPLE_BITS) - (SAMPLE_BITS+1)'(bl_f);
  assign bl_p   = (VAL_W+SAMPLE_BITS+2)'(bl_a) * (VAL_W+SAMPLE_BITS+2)'(bl_f)
                + (VAL_W+SAMPLE_BITS+2)'(bl_b) * (VAL_W+SAMPLE_BITS+2)'(bl_fc);
  assign bl_res = bl_p[SAMPLE_BITS +: VAL_W];

  // Noise table: at most one write and one read each cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[head.item.entry_address] <= head.item.entry_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Sequencer: state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      oct_r       <= '0;
      step_r      <= '0;
      sum_r       <= '0;
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (pop && head.item.command == CMD_SAMPLE) begin
            x_r     <= head.item.x_coord;
            y_r     <= head.item.y_coord;
            z_r     <= head.item.z_coord;
            oct_r   <= start_sat;
            sum_r   <= '0;
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          cx_r    <= cx_n;
          cmx_r   <= (cx_n == '0) ? XW'(TABLE_WIDTH - 1) : cx_n - 1'b1;
          cy_r    <= cy_n;
          cmy_r   <= (cy_n == '0) ? YW'(TABLE_HEIGHT - 1) : cy_n - 1'b1;
          cz_r    <= cz_n;
          cmz_r   <= (cz_n == '0) ? ZW'(TABLE_DEPTH - 1) : cz_n - 1'b1;
          fx_r    <= frx[SAMPLE_BITS-1:0];
          fy_r    <= fry[SAMPLE_BITS-1:0];
          fz_r    <= frz[SAMPLE_BITS-1:0];
          step_r  <= '0;
          state_r <= ST_RUN;
        end
        ST_RUN: begin
          step_r <= step_r + 1'b1;
          if (step_r >= 4'd1 && step_r <= 4'd8) begin
            v_r[3'(step_r - 4'd1)] <= rd_data_r;
          end
          case (step_r)
            4'd9, 4'd13: v_r[0] <= bl_res;
            4'd10:       v_r[2] <= bl_res;
            4'd11, 4'd14: v_r[4] <= bl_res;
            4'd12:       v_r[6] <= bl_res;
            default: ;
          endcase
          if (step_r == LAST_STEP) begin
            sum_r <= sum_r + (SUM_W'(bl_res) << oct_r);
            if (oct_r == '0) begin
              state_r <= ST_DONE;
            end else begin
              oct_r   <= oct_r - 1'b1;
              state_r <= ST_SETUP;
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_value_r <= VAL_W'(sum_r >> (start_sat + 1'b1));
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == ST_IDLE) else $error("table write while busy");
  a_oct_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> oct_r <= start_sat) else $error("octave out of range");
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && (!out_valid_r || !out_stall) |=> out_valid_r)
    else $error("result not posted");

endmodule

/* tb/value_noise_turbulence_3d_core_tb.sv */
`timescale 1ns / 1ps
module value_noise_turbulence_3d_core_tb;
  import vnt_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int SETTLE_TICKS = 24;
  localparam int HOLD_TICKS   = 400;
  localparam int PHASE_ITEMS  = 60;

  typedef struct {
    cmd_t         cmd;
    logic [23:0]  px;
    logic [23:0]  py;
    logic [23:0]  pz;
    logic [15:0]  addr;
    logic [15:0]  val;
    bit           known;
    logic [15:0]  golden;
  } request_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_command;
  logic [COORD_W-1:0] in_x_coord;
  logic [COORD_W-1:0] in_y_coord;
  logic [COORD_W-1:0] in_z_coord;
  logic [ADDR_W-1:0] in_entry_address;
  logic [VAL_W-1:0] in_entry_value;
  logic out_valid;
  logic out_stall;
  logic [VAL_W-1:0] out_turbulence_value;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  // Mirror of the block's table and register
  logic [15:0] noise_copy [0:65535];
  int          octave_top;

  logic [15:0] pending_turbulence [$];
  int          mismatches;
  int          cycles;
  int          sample_count;
  int          load_count;
  int          result_count;
  bit          calm;
  bit          hold_req;

  value_noise_turbulence_3d_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command           (in_command),
    .in_x_coord           (in_x_coord),
    .in_y_coord           (in_y_coord),
    .in_z_coord           (in_z_coord),
    .in_entry_address     (in_entry_address),
    .in_entry_value       (in_entry_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_turbulence_value (out_turbulence_value),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Weighted blend of corner c and its neighbor c-1
  function automatic logic [15:0] mix(input logic [15:0] at_c, input logic [15:0] at_cm1,
                                      input logic [15:0] f);
    logic [33:0] acc;
    acc = 34'(at_c) * 34'(f) + 34'(at_cm1) * (34'h10000 - 34'(f));
    return acc[31:16];
  endfunction

  function automatic logic [15:0] entry_at(input logic [5:0] xi, input logic [5:0] yi,
                                           input logic [3:0] zi);
    return noise_copy[{zi, yi, xi}];
  endfunction

  // Trilinear value of one octave of size 2^s
  function automatic logic [15:0] octave_noise(input logic [23:0] px, input logic [23:0] py,
                                               input logic [23:0] pz, input int s);
    logic [47:0] wx, wy, wz;
    logic [23:0] ix, iy, iz;
    logic [5:0]  xc, xm, yc, ym;
    logic [3:0]  zc, zm;
    logic [15:0] a, b, c, d, e, f;
    wx = ({24'd0, px} << 16) >> (8 + s);
    wy = ({24'd0, py} << 16) >> (8 + s);
    wz = ({24'd0, pz} << 16) >> (8 + s);
    ix = px >> (8 + s);
    iy = py >> (8 + s);
    iz = pz >> (8 + s);
    xc = ix[5:0];
    yc = iy[5:0];
    zc = iz[3:0];
    xm = xc - 6'd1;
    ym = yc - 6'd1;
    zm = zc - 4'd1;
    a = mix(entry_at(xc, yc, zc), entry_at(xm, yc, zc), wx[15:0]);
    b = mix(entry_at(xc, ym, zc), entry_at(xm, ym, zc), wx[15:0]);
    c = mix(entry_at(xc, yc, zm), entry_at(xm, yc, zm), wx[15:0]);
    d = mix(entry_at(xc, ym, zm), entry_at(xm, ym, zm), wx[15:0]);
    e = mix(a, b, wy[15:0]);
    f = mix(c, d, wy[15:0]);
    return mix(e, f, wz[15:0]);
  endfunction

  // Sum octaves weighted by size, scale to Q8.8
  function automatic logic [15:0] turbulence_at(input logic [23:0] px, input logic [23:0] py,
                                                input logic [23:0] pz);
    logic [24:0] sum;
    logic [24:0] scaled;
    int s;
    sum = '0;
    for (s = octave_top; s >= 0; s--)
      sum += 25'(octave_noise(px, py, pz, s)) << s;
    scaled = sum >> (octave_top + 1);
    return scaled[15:0];
  endfunction

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
    mismatches++;
  endtask

  // Drive one request; on acceptance update the mirror and queue the expectation
  task automatic send_request(input request_row_t r);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= r.cmd;
    in_x_coord       <= r.px;
    in_y_coord       <= r.py;
    in_z_coord       <= r.pz;
    in_entry_address <= r.addr;
    in_entry_value   <= r.val;
    do @(posedge clk); while (in_stall);
    if (r.cmd == CMD_LOAD) begin
      noise_copy[r.addr] = r.val;
      load_count++;
    end else begin
      pending_turbulence.push_back(r.known ? r.golden : turbulence_at(r.px, r.py, r.pz));
      sample_count++;
    end
    @(negedge clk);
  endtask

  // Drop valid, drain expectations, let trailing loads finish
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_turbulence.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic write_start(input logic [3:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    octave_top = (v > 4'd8) ? 8 : int'(v);
    @(negedge clk);
  endtask

  // Integer part 0..3 or all ones, so every corner lands in the preloaded rows
  function automatic logic [23:0] pick_coord;
    int m;
    m = $urandom_range(9);
    if (m == 0) return 24'd0;
    if (m == 1) return 24'hFFFFFF;
    if (m == 2) return {16'hFFFF, 8'($urandom())};
    return {16'($urandom_range(3)), 8'($urandom())};
  endfunction

  function automatic request_row_t random_request;
    request_row_t r;
    int m;
    r.cmd  = ($urandom_range(99) < 30) ? CMD_LOAD : CMD_SAMPLE;
    r.px   = pick_coord();
    r.py   = pick_coord();
    r.pz   = pick_coord();
    m      = $urandom_range(9);
    r.addr = (m == 0) ? 16'h0000 : (m == 1) ? 16'hFFFF : 16'($urandom());
    m      = $urandom_range(9);
    r.val  = (m == 0) ? 16'h0000 : (m == 1) ? 16'hFFFF : 16'($urandom());
    r.known  = 1'b0;
    r.golden = '0;
    return r;
  endfunction

  task automatic random_phase(input int count);
    repeat (count) send_request(random_request());
  endtask

  // Directed rows, run with a single octave; the first sample reads only the
  // eight corners loaded just before it
  request_row_t directed [] = '{
    '{CMD_LOAD,   24'h0, 24'h0, 24'h0, 16'd0,     16'hFFFF, 1'b0, 16'h0},
    '{CMD_LOAD,   24'h0, 24'h0, 24'h0, 16'd63,    16'hFFFF, 1'b0, 16'h0},
    '{CMD_LOAD,   24'h0, 24'h0, 24'h0, 16'd4032,  16'hFFFF, 1'b0, 16'h0},
    '{CMD_LOAD,   24'h0, 24'h0, 24'h0, 16'd4095,  16'hFFFF, 1'b0, 16'h0},
    '{CMD_LOAD,   24'h0, 24'h0, 24'h0, 16'd61440, 16'hFFFF, 1'b0, 16'h0},
    '{CMD_LOAD,   24'h0, 24'h0, 24'h0, 16'd61503, 16'hFFFF, 1'b0, 16'h0},
    '{CMD_LOAD,   24'h0, 24'h0, 24'h0, 16'd65472, 16'hFFFF, 1'b0, 16'h0},
    '{CMD_LOAD,   24'h0, 24'h0, 24'h0, 16'd65535, 16'hFFFF, 1'b0, 16'h0},
    '{CMD_SAMPLE, 24'h0, 24'h0, 24'h0, 16'd0,     16'h0,    1'b1, 16'h7FFF},
    '{CMD_SAMPLE, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0},
    '{CMD_SAMPLE, 24'h0000FF, 24'h0000FF, 24'h0000FF, 16'h0, 16'h0, 1'b0, 16'h0},
    '{CMD_SAMPLE, 24'h000080, 24'hFFFF00, 24'h7FFFFF, 16'h0, 16'h0, 1'b0, 16'h0},
    '{CMD_LOAD,   24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'd0, 16'h0000, 1'b0, 16'h0},
    '{CMD_LOAD,   24'h0, 24'h0, 24'h0, 16'd65535, 16'h0000, 1'b0, 16'h0},
    '{CMD_SAMPLE, 24'h0, 24'h0, 24'h0, 16'd0, 16'h0, 1'b0, 16'h0},
    '{CMD_LOAD,   24'h0, 24'h0, 24'h0, 16'h5555, 16'h8000, 1'b0, 16'h0},
    '{CMD_SAMPLE, 24'h00FF80, 24'h3F0001, 24'hC00040, 16'h0, 16'h0, 1'b0, 16'h0}
  };

  // Count cycles, end on runaway
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL value_noise_turbulence_3d_core");
      $finish;
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      result_count <= result_count + 1;
      if (pending_turbulence.size() == 0)
        report("unexpected result", out_turbulence_value, 16'h0);
      else if (out_turbulence_value !== pending_turbulence[0])
        report("turbulence_value", out_turbulence_value, pending_turbulence.pop_front());
      else
        void'(pending_turbulence.pop_front());
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_TICKS) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 19);
      end
    end
  end

  initial begin
    request_row_t r;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_command       = CMD_SAMPLE;
    in_x_coord       = '0;
    in_y_coord       = '0;
    in_z_coord       = '0;
    in_entry_address = '0;
    in_entry_value   = '0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    cycles           = 0;
    mismatches       = 0;
    sample_count     = 0;
    load_count       = 0;
    result_count     = 0;
    octave_top       = 5;
    calm             = 1'b1;
    hold_req         = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Load every entry a sample can reach: rows -2..3 around zero on each axis,
    // wrapping, with no idling on either side
    for (int zi = 0; zi < 6; zi++)
      for (int yi = 0; yi < 6; yi++)
        for (int xi = 0; xi < 6; xi++) begin
          r = random_request();
          r.cmd  = CMD_LOAD;
          r.addr = 16'(((zi + 14) % 16) * 4096 + ((yi + 62) % 64) * 64 + (xi + 62) % 64);
          send_request(r);
        end
    drain();
    calm = 1'b0;

    write_start(4'd0);
    foreach (directed[i]) send_request(directed[i]);
    drain();

    // Default size, with a long receiver hold-off at the start
    write_start(4'd5);
    hold_req = 1'b1;
    random_phase(PHASE_ITEMS);
    drain();

    write_start(4'd8);
    random_phase(PHASE_ITEMS);
    drain();

    write_start(4'd15);
    random_phase(PHASE_ITEMS);
    drain();

    write_start(4'd3);
    random_phase(PHASE_ITEMS);
    drain();

    write_start(4'd1);
    random_phase(PHASE_ITEMS);
    drain();

    write_start(4'($urandom_range(15)));
    random_phase(PHASE_ITEMS);
    drain();

    $display("covered %0d samples and %0d loads, %0d results checked", sample_count,
             load_count, result_count);
    $display("start sizes 0, 1, 3, 5, 8, a saturating and a random one, one long hold-off");
    if (mismatches == 0)
      $display("PASS value_noise_turbulence_3d_core");
    else
      $display("FAIL value_noise_turbulence_3d_core");
    $finish;
  end

endmodule
